### rtl/aprm_pkg.sv
// ----------------------------------------------------------------------------
// aprm_pkg
// Shared types and constants of the audio peak and RMS level meter.
// ----------------------------------------------------------------------------
package aprm_pkg;

    localparam int SAMPLE_BITS_DEF  = 24;
    localparam int COUNT_BITS_DEF   = 16;
    localparam int MAX_CHANNELS_DEF = 2;

    localparam int FIELD_W    = 24;
    localparam int FRAMES_W   = 16;
    localparam int IN_DATA_W  = 48;
    localparam int IN_USER_W  = 2;
    localparam int OUT_DATA_W = 120;
    localparam int CFG_W      = 2;

    localparam logic [CFG_W-1:0] CH_COUNT_RESET = 2'd2;

    localparam logic [IN_USER_W-1:0] REQ_FRAME = 2'd0;
    localparam logic [IN_USER_W-1:0] REQ_READ  = 2'd1;
    localparam logic [IN_USER_W-1:0] REQ_CLEAR = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SQ,
        S_ACC,
        S_DIV,
        S_SQINIT,
        S_SQRT,
        S_STORE,
        S_OUT
    } t_state;

    typedef struct packed {
        logic frame;
        logic rd_start;
        logic clear;
        logic sq;
        logic sq_ch;
        logic acc;
        logic acc_ch;
        logic div_init;
        logic div_step;
        logic sqrt_init;
        logic sqrt_step;
        logic rms_store;
        logic rms_ch;
        logic ch;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic act0;
        logic act1;
        logic sat;
        logic count_zero;
        logic ovf;
        logic out_free;
    } t_stat;

endpackage

### rtl/aprm_ctrl.sv
// ----------------------------------------------------------------------------
// aprm_ctrl
// Sequencer: frame accumulation, divide and square root steps, result load.
// ----------------------------------------------------------------------------
module aprm_ctrl
    import aprm_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
    parameter int COUNT_BITS  = COUNT_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  logic [IN_USER_W-1:0] i_req,
    output logic                 o_ready,
    input  t_stat                i_stat,
    output t_cmd                 o_cmd
);

    localparam int SUM_BITS = 2 * SAMPLE_BITS + COUNT_BITS - 2;
    localparam int CNT_W    = $clog2(SUM_BITS);

    t_state           r_state, n_state;
    logic             r_ch, n_ch;
    logic [CNT_W-1:0] r_cnt, n_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ch    <= 1'b0;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_ch    <= n_ch;
            r_cnt   <= n_cnt;
        end
    end

    always_comb begin
        n_state = r_state;
        n_ch    = r_ch;
        n_cnt   = r_cnt;
        o_cmd   = '0;
        o_ready = (r_state == S_IDLE);
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    case (i_req)
                        REQ_FRAME: begin
                            if (i_stat.act0) begin
                                o_cmd.frame = 1'b1;
                                if (!i_stat.sat) begin
                                    n_state = S_SQ;
                                end
                            end
                        end
                        REQ_READ: begin
                            o_cmd.rd_start = 1'b1;
                            n_ch = 1'b0;
                            if (i_stat.count_zero || !i_stat.act0) begin
                                n_state = S_OUT;
                            end else begin
                                o_cmd.div_init = 1'b1;
                                o_cmd.ch       = 1'b0;
                                n_cnt   = CNT_W'(SUM_BITS - 1);
                                n_state = S_DIV;
                            end
                        end
                        REQ_CLEAR: begin
                            o_cmd.clear = 1'b1;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_SQ: begin
                o_cmd.sq    = 1'b1;
                o_cmd.sq_ch = 1'b0;
                n_ch    = 1'b0;
                n_state = S_ACC;
            end
            S_ACC: begin
                o_cmd.acc    = 1'b1;
                o_cmd.acc_ch = r_ch;
                if (!r_ch && i_stat.act1) begin
                    o_cmd.sq    = 1'b1;
                    o_cmd.sq_ch = 1'b1;
                    n_ch = 1'b1;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (r_cnt == '0) begin
                    n_state = S_SQINIT;
                end else begin
                    n_cnt = r_cnt - 1'b1;
                end
            end
            S_SQINIT: begin
                o_cmd.sqrt_init = 1'b1;
                n_cnt   = CNT_W'(SAMPLE_BITS - 1);
                n_state = S_SQRT;
            end
            S_SQRT: begin
                o_cmd.sqrt_step = 1'b1;
                if (r_cnt == '0) begin
                    n_state = S_STORE;
                end else begin
                    n_cnt = r_cnt - 1'b1;
                end
            end
            S_STORE: begin
                o_cmd.rms_store = 1'b1;
                o_cmd.rms_ch    = r_ch;
                if (!r_ch && i_stat.act1) begin
                    o_cmd.div_init = 1'b1;
                    o_cmd.ch       = 1'b1;
                    n_ch    = 1'b1;
                    n_cnt   = CNT_W'(SUM_BITS - 1);
                    n_state = S_DIV;
                end else begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

### rtl/aprm_dp.sv
// ----------------------------------------------------------------------------
// aprm_dp
// Datapath: peaks, shared squarer, sums, frame count, restoring divider,
// digit-by-digit square root and the result register.
// ----------------------------------------------------------------------------
module aprm_dp
    import aprm_pkg::*;
#(
    parameter int SAMPLE_BITS  = SAMPLE_BITS_DEF,
    parameter int COUNT_BITS   = COUNT_BITS_DEF,
    parameter int MAX_CHANNELS = MAX_CHANNELS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_cmd                  i_cmd,
    output t_stat                 o_stat,
    input  logic [FIELD_W-1:0]    i_left_sample,
    input  logic [FIELD_W-1:0]    i_right_sample,
    input  logic                  i_cfg_valid,
    input  logic [CFG_W-1:0]      i_cfg_data,
    input  logic                  i_out_ready,
    output logic                  o_out_valid,
    output logic [OUT_DATA_W-1:0] o_out_data
);

    localparam int S        = SAMPLE_BITS;
    localparam int C        = COUNT_BITS;
    localparam int SUM_BITS = 2 * S + C - 2;

    logic [CFG_W-1:0]    r_cc;
    logic [C-1:0]        r_count;
    logic                r_ovf;
    logic                r_out_valid;
    logic [OUT_DATA_W-1:0] r_out_data;

    logic [S-1:0]        r_peak [MAX_CHANNELS];
    logic [SUM_BITS-1:0] r_sum  [MAX_CHANNELS];
    logic [S-1:0]        r_mag  [MAX_CHANNELS];
    logic [S-1:0]        r_rms  [MAX_CHANNELS];
    logic [S-1:0]        w_mag  [MAX_CHANNELS];
    logic [MAX_CHANNELS-1:0] w_act;
    logic [FIELD_W-1:0]  w_raw  [2];

    logic [2*S-1:0]      r_prod;
    logic [S-1:0]        w_sq_op;
    logic [SUM_BITS-1:0] w_dividend;

    logic [SUM_BITS-1:0] r_dq;
    logic [C-1:0]        r_rem;
    logic [C:0]          w_div_t;
    logic                w_div_ge;

    logic [2*S-1:0]      r_sx;
    logic [S+1:0]        r_srem;
    logic [S-1:0]        r_root;
    logic [S+3:0]        w_sq_t;
    logic [S+3:0]        w_sq_trial;
    logic                w_sq_ge;

    logic                w_sat;
    logic                w_act1;
    logic                w_wipe;
    logic [FIELD_W-1:0]  w_peak0, w_peak1, w_rms0, w_rms1;

    assign w_raw[0] = i_left_sample;
    assign w_raw[1] = i_right_sample;
    assign w_sat    = (r_count == '1);
    assign w_wipe   = i_cmd.clear || i_cmd.out_load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cc <= CH_COUNT_RESET;
        end else if (i_cfg_valid) begin
            r_cc <= i_cfg_data;
        end
    end

    for (genvar c = 0; c < MAX_CHANNELS; c++) begin : g_ch
        logic [S-1:0] w_v;
        assign w_v      = w_raw[c][S-1:0];
        assign w_mag[c] = w_v[S-1] ? (~w_v + 1'b1) : w_v;
        assign w_act[c] = (32'(r_cc) > c) && (32'(r_cc) <= MAX_CHANNELS);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_peak[c] <= '0;
                r_sum[c]  <= '0;
            end else if (w_wipe) begin
                r_peak[c] <= '0;
                r_sum[c]  <= '0;
            end else begin
                if (i_cmd.frame && w_act[c] && (w_mag[c] > r_peak[c])) begin
                    r_peak[c] <= w_mag[c];
                end
                if (i_cmd.acc && (i_cmd.acc_ch == 1'(c))) begin
                    r_sum[c] <= r_sum[c] + SUM_BITS'(r_prod);
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_cmd.frame) begin
                r_mag[c] <= w_mag[c];
            end
            if (i_cmd.rd_start) begin
                r_rms[c] <= '0;
            end else if (i_cmd.rms_store && (i_cmd.rms_ch == 1'(c))) begin
                r_rms[c] <= r_root;
            end
        end
    end

    assign w_act1 = (MAX_CHANNELS > 1) ? w_act[MAX_CHANNELS-1] : 1'b0;

    always_comb begin
        w_sq_op    = r_mag[0];
        w_dividend = r_sum[0];
        if (MAX_CHANNELS > 1 && i_cmd.sq_ch) begin
            w_sq_op = r_mag[MAX_CHANNELS-1];
        end
        if (MAX_CHANNELS > 1 && i_cmd.ch) begin
            w_dividend = r_sum[MAX_CHANNELS-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.sq) begin
            r_prod <= w_sq_op * w_sq_op;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_ovf   <= 1'b0;
        end else if (w_wipe) begin
            r_count <= '0;
            r_ovf   <= 1'b0;
        end else if (i_cmd.frame) begin
            if (w_sat) begin
                r_ovf <= 1'b1;
            end else begin
                r_count <= r_count + 1'b1;
            end
        end
    end

    // restoring divide, one quotient bit per step
    assign w_div_t  = {r_rem, r_dq[SUM_BITS-1]};
    assign w_div_ge = (w_div_t >= {1'b0, r_count});

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_init) begin
            r_dq  <= w_dividend;
            r_rem <= '0;
        end else if (i_cmd.div_step) begin
            r_rem <= w_div_ge ? C'(w_div_t - {1'b0, r_count}) : C'(w_div_t);
            r_dq  <= {r_dq[SUM_BITS-2:0], w_div_ge};
        end
    end

    // square root, two radicand bits per step
    assign w_sq_t     = {r_srem, r_sx[2*S-1 -: 2]};
    assign w_sq_trial = {2'b00, r_root, 2'b01};
    assign w_sq_ge    = (w_sq_t >= w_sq_trial);

    always_ff @(posedge i_clk) begin
        if (i_cmd.sqrt_init) begin
            r_sx   <= r_dq[2*S-1:0];
            r_srem <= '0;
            r_root <= '0;
        end else if (i_cmd.sqrt_step) begin
            r_srem <= w_sq_ge ? (S+2)'(w_sq_t - w_sq_trial) : (S+2)'(w_sq_t);
            r_root <= {r_root[S-2:0], w_sq_ge};
            r_sx   <= {r_sx[2*S-3:0], 2'b00};
        end
    end

    assign w_peak0 = w_act[0] ? FIELD_W'(r_peak[0]) : '0;
    assign w_peak1 = w_act1 ? FIELD_W'(r_peak[MAX_CHANNELS-1]) : '0;
    assign w_rms0  = FIELD_W'(r_rms[0]);
    assign w_rms1  = (MAX_CHANNELS > 1) ? FIELD_W'(r_rms[MAX_CHANNELS-1]) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_data <= {7'b0, r_ovf, FRAMES_W'(r_count),
                           w_rms1, w_rms0, w_peak1, w_peak0};
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    assign o_stat.act0       = w_act[0];
    assign o_stat.act1       = w_act1;
    assign o_stat.sat        = w_sat;
    assign o_stat.count_zero = (r_count == '0);
    assign o_stat.ovf        = r_ovf;
    assign o_stat.out_free   = !r_out_valid || i_out_ready;

endmodule

### rtl/audio_peak_rms_meter_unit.sv
// ----------------------------------------------------------------------------
// audio_peak_rms_meter_unit
// Audio peak and RMS level meter, one or two Q1.23 channels.
// ----------------------------------------------------------------------------
// Input stream: tuser carries the request (frame, read and clear, clear),
// tdata the left and right samples. Output stream: one item per read.
// Config channel: writes the channel count (1 mono, 2 stereo), always ready.
// A frame passes through accept, squarer and sum add; in stereo the second
// channel is squared and added through the one shared squarer. An ignored
// or saturated frame and a clear end at accept. A read runs the restoring
// divider (SUM_BITS steps) and the square root (SAMPLE_BITS steps) once per
// active channel before the result register loads; with no frames counted
// or channel 0 inactive it goes straight to the load.
// Input tready is high only while the sequencer is idle.
// Reset clears peaks, sums, count and overflow flag and sets stereo.
// A result waits in the output register while the receiver stalls; frames
// are still taken, and a following read holds once done until the slot frees.
// ----------------------------------------------------------------------------
module audio_peak_rms_meter_unit
    import aprm_pkg::*;
#(
    parameter int SAMPLE_BITS  = SAMPLE_BITS_DEF,
    parameter int COUNT_BITS   = COUNT_BITS_DEF,
    parameter int MAX_CHANNELS = MAX_CHANNELS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,  // left_sample, right_sample
    input  logic [IN_USER_W-1:0]  s_axis_tuser,  // req_type
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // peak_left, peak_right, rms_left, rms_right, frames_counted, count_overflow
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_W-1:0]      i_cfg_data     // channel_count
);

    t_cmd  w_cmd;
    t_stat w_stat;

    assign o_cfg_ready = 1'b1;

    aprm_ctrl #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .COUNT_BITS  (COUNT_BITS)
    ) u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .i_req   (s_axis_tuser),
        .o_ready (s_axis_tready),
        .i_stat  (w_stat),
        .o_cmd   (w_cmd)
    );

    aprm_dp #(
        .SAMPLE_BITS  (SAMPLE_BITS),
        .COUNT_BITS   (COUNT_BITS),
        .MAX_CHANNELS (MAX_CHANNELS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .o_stat         (w_stat),
        .i_left_sample  (s_axis_tdata[FIELD_W-1:0]),
        .i_right_sample (s_axis_tdata[2*FIELD_W-1:FIELD_W]),
        .i_cfg_valid    (i_cfg_valid),
        .i_cfg_data     (i_cfg_data),
        .i_out_ready    (m_axis_tready),
        .o_out_valid    (m_axis_tvalid),
        .o_out_data     (m_axis_tdata)
    );

`ifndef NO_ASSERTIONS
    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.out_load |-> (!m_axis_tvalid || m_axis_tready))
        else $error("result loaded over a waiting item");

    a_load_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.out_load |=> m_axis_tvalid)
        else $error("loaded result not presented");

    a_ovf_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_stat.ovf |-> w_stat.sat)
        else $error("overflow flag without saturated count");

    a_div_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.div_step |-> !w_stat.count_zero)
        else $error("divide step with zero frame count");
`endif

endmodule
